FILE: rtl/mtwg_pkg.sv
// ============================================================================
// mtwg_pkg - shared types and constants for the MT19937 word generator
// Widths, generator constants, tempering and index helpers.
// ============================================================================
package mtwg_pkg;

  localparam int WORD_W      = 32;
  localparam int DRAW_W      = 7;
  localparam int STATE_WORDS = 624;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int MID_OFFSET  = 397;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WORD_W-1:0] INIT_MULT    = 32'h6C07_8965;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_MID  = IDX_W'(MID_OFFSET);

  // register map, index = paddr[2]
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_TEMPER = 1'b1;

  typedef struct packed {
    logic              seed_load;
    logic              temper_en;
    logic [WORD_W-1:0] seed;
  } mtwg_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mtwg_qstat_t;

  // next state index with wrap at the end of the state array
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    idx_inc = (x == IDX_LAST) ? '0 : x + IDX_W'(1);
  endfunction

  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    temper_word = y;
  endfunction

endpackage

FILE: rtl/mtwg_req_if.sv
// ============================================================================
// mtwg_req_if - request channel
// Carries one request (number of words wanted) with valid/ready.
// ============================================================================
interface mtwg_req_if import mtwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] draws;

  modport source (output valid, output draws, input ready);
  modport sink   (input valid, input draws, output ready);
endinterface

FILE: rtl/mtwg_word_if.sv
// ============================================================================
// mtwg_word_if - result word channel
// Carries one generated word and its end-of-request flag with valid/ready.
// ============================================================================
interface mtwg_word_if import mtwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;
  logic              last;

  modport source (output valid, output random_word, output last, input ready);
  modport sink   (input valid, input random_word, input last, output ready);
endinterface

FILE: rtl/mersenne_twister_word_generator.sv
// ============================================================================
// mersenne_twister_word_generator - MT19937 32-bit word generator
// Request-driven generator with APB seed/tempering registers.
// ============================================================================
// Usage:
//   in_chan  : one request per handshake, draws = words wanted. A request of
//              zero words is taken and dropped; more than MAX_DRAWS is clamped.
//   out_chan : one word per handshake, last set on the final word of a request.
//   APB      : reg 0 (0x0) seed, reg 1 (0x4) temper enable (bit 0). A seed
//              write rebuilds the 624-word state.
// Operation:
//   After reset the state is rebuilt one word per cycle through the seeding
//   multiplier, followed by the prefetch state; a seed write starts the same
//   rebuild from the registered load strobe. Queued requests wait for it.
//   After that the twist is applied to each word as it is drawn, one state
//   memory write and two reads per cycle while the output is free. A request
//   passes the queue fill count and the have_r flag before its first word
//   reaches the output register; a queued request follows without a gap.
//   Reset: seed 5489, tempering on, queue empty, state rebuilt as above.
//   A stalled receiver holds the word in the output register and freezes the
//   engine; up to 4 requests queue in front.
// ============================================================================
module mersenne_twister_word_generator import mtwg_pkg::*; #(
  parameter int MAX_DRAWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  mtwg_req_if.sink          in_chan,
  mtwg_word_if.source       out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  // request count width follows the clamp limit, never above the field width
  localparam int CNT_RAW = $clog2(MAX_DRAWS + 1);
  localparam int CNT_W   = (CNT_RAW < DRAW_W) ? CNT_RAW : DRAW_W;

  logic [WORD_W-1:0] seed_r;
  logic              temper_r;
  logic              wr_en;
  logic              seed_load_r;
  mtwg_cfg_t         cfg;
  mtwg_qstat_t       qstat;
  logic              push, pop;
  logic [CNT_W-1:0]  push_cnt, pop_cnt;

  // APB registers, no wait states
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_TEMPER) ? {{(WORD_W-1){1'b0}}, temper_r} : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      temper_r    <= 1'b1;
      seed_load_r <= 1'b0;
    end else begin
      seed_load_r <= wr_en & (paddr[2] == REG_SEED);
      if (wr_en) begin
        case (paddr[2])
          REG_SEED:   seed_r   <= pwdata;
          REG_TEMPER: temper_r <= pwdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // seed_load is registered, so the engine sees it once seed_r holds the new seed
  assign cfg.seed_load = seed_load_r;
  assign cfg.temper_en = temper_r;
  assign cfg.seed      = seed_r;

  mtwg_front #(
    .MAX_DRAWS (MAX_DRAWS),
    .CNT_W     (CNT_W)
  ) u_front (
    .req      (in_chan),
    .qstat    (qstat),
    .push     (push),
    .push_cnt (push_cnt)
  );

  mtwg_queue #(
    .CNT_W (CNT_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cnt (push_cnt),
    .pop      (pop),
    .pop_cnt  (pop_cnt),
    .qstat    (qstat)
  );

  mtwg_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .qstat   (qstat),
    .pop_cnt (pop_cnt),
    .pop     (pop),
    .word    (out_chan)
  );

endmodule

FILE: rtl/mtwg_front.sv
// ============================================================================
// mtwg_front - request intake
// Accepts requests, drops empty ones and clamps the count to MAX_DRAWS.
// ============================================================================
module mtwg_front import mtwg_pkg::*; #(
  parameter int MAX_DRAWS = 64,
  parameter int CNT_W     = 7
) (
  mtwg_req_if.sink          req,
  input  mtwg_qstat_t       qstat,
  output logic              push,
  output logic [CNT_W-1:0]  push_cnt
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DRAWS);

  logic over;

  assign req.ready = ~qstat.full;
  assign over      = (32'(req.draws) > MAX_DRAWS);
  assign push_cnt  = over ? MAX_CNT : req.draws[CNT_W-1:0];
  // zero-word requests are taken and discarded
  assign push      = req.valid & req.ready & (req.draws != '0);

endmodule

FILE: rtl/mtwg_queue.sv
// ============================================================================
// mtwg_queue - request queue
// Small register FIFO holding clamped request counts for the back end.
// ============================================================================
module mtwg_queue import mtwg_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [CNT_W-1:0] push_cnt,
  input  logic             pop,
  output logic [CNT_W-1:0] pop_cnt,
  output mtwg_qstat_t      qstat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]  slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign qstat.empty = (fill_r == '0);
  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign pop_cnt     = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (do_push & ~do_pop) fill_nxt = fill_r + FILL_W'(1);
    else if (do_pop & ~do_push) fill_nxt = fill_r - FILL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cnt;
  end

endmodule

FILE: rtl/mtwg_back.sv
// ============================================================================
// mtwg_back - generator engine
// State memory, seeding sequencer, one-word-per-cycle twist (held while the output stalls) and output reg.
// ============================================================================
module mtwg_back import mtwg_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mtwg_cfg_t        cfg,
  input  mtwg_qstat_t      qstat,
  input  logic [CNT_W-1:0] pop_cnt,
  output logic             pop,
  mtwg_word_if.source      word
);

  localparam logic [1:0] ST_SEED0 = 2'd0;
  localparam logic [1:0] ST_SEED  = 2'd1;
  localparam logic [1:0] ST_PREF  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [WORD_W-1:0] mem [STATE_WORDS];

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  k_r, n_r, f_r;     // word k, k+1 and k+397 (mod size)
  logic [IDX_W-1:0]  seed_idx_r;
  logic [WORD_W-1:0] prev_r;            // last seeded word
  logic [WORD_W-1:0] cur_r;             // mt[k]
  logic [WORD_W-1:0] rd_nxt_r, rd_far_r; // mt[k+1], mt[k+397]
  logic              have_r;
  logic [CNT_W-1:0]  rem_r;
  logic              out_valid_r, out_last_r;
  logic [WORD_W-1:0] out_word_r;

  logic              fire, out_free, last_word;
  logic              mem_we, rd_en;
  logic [IDX_W-1:0]  waddr, raddr_a, raddr_b;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] seed_mix, seed_prod, seed_word;
  logic [WORD_W-1:0] y, tw_word;

  // seeding recurrence
  assign seed_mix  = prev_r ^ (prev_r >> 30);
  assign seed_prod = INIT_MULT * seed_mix;
  assign seed_word = seed_prod + WORD_W'(seed_idx_r);

  // twist of word k, done as the word is drawn
  assign y       = {cur_r[WORD_W-1], rd_nxt_r[WORD_W-2:0]};
  assign tw_word = rd_far_r ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

  assign out_free  = ~out_valid_r | word.ready;
  assign fire      = (state_r == ST_RUN) & have_r & out_free;
  assign last_word = (rem_r == CNT_ONE);
  assign pop       = ~qstat.empty & (~have_r | (fire & last_word));

  always_comb begin
    mem_we  = 1'b0;
    waddr   = k_r;
    wdata   = tw_word;
    rd_en   = 1'b0;
    raddr_a = idx_inc(n_r);
    raddr_b = idx_inc(f_r);
    state_nxt = state_r;
    case (state_r)
      ST_SEED0: begin
        mem_we    = 1'b1;
        waddr     = '0;
        wdata     = cfg.seed;
        state_nxt = ST_SEED;
      end
      ST_SEED: begin
        mem_we = 1'b1;
        waddr  = seed_idx_r;
        wdata  = seed_word;
        if (seed_idx_r == IDX_LAST) state_nxt = ST_PREF;
      end
      ST_PREF: begin
        rd_en     = 1'b1;
        raddr_a   = n_r;
        raddr_b   = f_r;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        mem_we = fire;
        rd_en  = fire;
      end
      default: state_nxt = ST_SEED0;
    endcase
    if (cfg.seed_load) state_nxt = ST_SEED0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (rd_en) begin
      rd_nxt_r <= mem[raddr_a];
      rd_far_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        have_r <= 1'b1;
      end else if (fire & last_word) begin
        have_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem_r <= pop_cnt;
    end else if (fire) begin
      rem_r <= rem_r - CNT_ONE;
    end
    if (fire) begin
      out_word_r <= cfg.temper_en ? temper_word(tw_word) : tw_word;
      out_last_r <= last_word;
    end
    case (state_r)
      ST_SEED0: begin
        prev_r     <= cfg.seed;
        cur_r      <= cfg.seed;
        seed_idx_r <= IDX_W'(1);
        k_r        <= '0;
        n_r        <= IDX_W'(1);
        f_r        <= IDX_MID;
      end
      ST_SEED: begin
        prev_r     <= seed_word;
        seed_idx_r <= seed_idx_r + IDX_W'(1);
      end
      ST_RUN: begin
        if (fire) begin
          cur_r <= rd_nxt_r;
          k_r   <= idx_inc(k_r);
          n_r   <= idx_inc(n_r);
          f_r   <= idx_inc(f_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign word.valid       = out_valid_r;
  assign word.random_word = out_word_r;
  assign word.last        = out_last_r;

endmodule
